// ===== hw/rtl/spk_pkg.sv =====
// Shared types, constants and round functions for the Speck 64/128 core.
package spk_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ROT_A      = 8;
  localparam int unsigned ROT_B      = 3;
  localparam int unsigned CFG_INDEX_W = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_WORD3 = 3'd3;

  typedef logic [WORD_W-1:0] word_t;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  // one block in flight
  typedef struct packed {
    logic  op;
    word_t x;
    word_t y;
  } blk_t;

  function automatic word_t rotr_a(input word_t v);
    return {v[ROT_A-1:0], v[WORD_W-1:ROT_A]};
  endfunction

  function automatic word_t rotl_a(input word_t v);
    return {v[WORD_W-ROT_A-1:0], v[WORD_W-1:WORD_W-ROT_A]};
  endfunction

  function automatic word_t rotr_b(input word_t v);
    return {v[ROT_B-1:0], v[WORD_W-1:ROT_B]};
  endfunction

  function automatic word_t rotl_b(input word_t v);
    return {v[WORD_W-ROT_B-1:0], v[WORD_W-1:WORD_W-ROT_B]};
  endfunction

endpackage

// ===== hw/rtl/spk_sched.sv =====
// Key registers and iterative key schedule, one round key per cycle.
module spk_sched #(
  parameter int ROUNDS = 27
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [spk_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  spk_pkg::word_t                     cfg_data,
  output logic [ROUNDS-1:0][spk_pkg::WORD_W-1:0] round_keys,
  output logic                               keys_ready
);

  localparam int CW = $clog2(ROUNDS + 1);

  spk_pkg::word_t key_reg [4];
  spk_pkg::word_t k, l0, l1, l2;
  spk_pkg::word_t nl, k_next;
  logic [CW-1:0]  cnt;   // index of next round key; 0 = load, ROUNDS = done

  assign keys_ready = (cnt == CW'(ROUNDS));

  always_comb begin
    nl     = (spk_pkg::rotr_a(l0) + k) ^ spk_pkg::word_t'(cnt - CW'(1));
    k_next = spk_pkg::rotl_b(k) ^ nl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg[0] <= '0;
      key_reg[1] <= '0;
      key_reg[2] <= '0;
      key_reg[3] <= '0;
      cnt        <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spk_pkg::REG_KEY_WORD0: begin key_reg[0] <= cfg_data; cnt <= '0; end
        spk_pkg::REG_KEY_WORD1: begin key_reg[1] <= cfg_data; cnt <= '0; end
        spk_pkg::REG_KEY_WORD2: begin key_reg[2] <= cfg_data; cnt <= '0; end
        spk_pkg::REG_KEY_WORD3: begin key_reg[3] <= cfg_data; cnt <= '0; end
        default: ;
      endcase
    end else if (cnt == '0) begin
      k   <= key_reg[0];
      l0  <= key_reg[1];
      l1  <= key_reg[2];
      l2  <= key_reg[3];
      cnt <= CW'(1);
    end else if (!keys_ready) begin
      k   <= k_next;
      l0  <= l1;
      l1  <= l2;
      l2  <= nl;
      cnt <= cnt + CW'(1);
    end
  end

  // round key storage, each entry written at its own schedule step
  always_ff @(posedge clk) begin
    if (!rst && !cfg_write) begin
      if (cnt == '0) round_keys[0] <= key_reg[0];
      for (int j = 1; j < ROUNDS; j++) begin
        if (cnt == CW'(j)) round_keys[j] <= k_next;
      end
    end
  end

endmodule

// ===== hw/rtl/spk_round.sv =====
// One registered round stage, encrypt or decrypt per word.
module spk_round (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  spk_pkg::blk_t  up_word,
  output logic           dn_valid,
  input  logic           dn_ready,
  output spk_pkg::blk_t  dn_word,
  input  spk_pkg::word_t rk_enc,
  input  spk_pkg::word_t rk_dec
);

  spk_pkg::blk_t  res;
  spk_pkg::word_t ex, dy;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    ex = (spk_pkg::rotr_a(up_word.x) + up_word.y) ^ rk_enc;
    dy = spk_pkg::rotr_b(up_word.y ^ up_word.x);
    res.op = up_word.op;
    if (up_word.op == spk_pkg::OP_DECRYPT) begin
      res.y = dy;
      res.x = spk_pkg::rotl_a((up_word.x ^ rk_dec) - dy);
    end else begin
      res.x = ex;
      res.y = spk_pkg::rotl_b(up_word.y) ^ ex;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word <= res;
    end
  end

endmodule

// ===== hw/rtl/speck64_128_block_cipher_core.sv =====
// Top level of the Speck 64/128 ECB cipher core.
//
// Usage:
//   Write the four 32-bit key words on the cfg channel (index 0..3, others
//   ignored, though any cfg word holds the schedule for that cycle) while the
//   core is empty. Each key write restarts the key schedule, which forms one round
//   key per cycle while no cfg word is written; in_ready stays low until the
//   schedule is done, also after the last reset cycle.
//   Reset clears the key to zero and schedules that key.
//   Then send words on the in channel: op (0 encrypt, 1 decrypt) and the
//   64-bit block as block_low (y) and block_high (x). Results leave on the
//   out channel as out_low / out_high.
// Timing:
//   One register stage per round, ROUNDS stages. One word per cycle is
//   accepted and delivered when the output is taken and the keys are ready.
//   Each stage carries its own valid bit and stalls only when its successor
//   is full, so with out_ready low bubbles are squeezed out and inputs are
//   still taken until every stage holds a word. Nothing is dropped or
//   duplicated under stall.
module speck64_128_block_cipher_core #(
  parameter int ROUNDS = 27
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            op,
  input  logic [31:0]                     block_low,
  input  logic [31:0]                     block_high,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     out_low,
  output logic [31:0]                     out_high,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  logic [ROUNDS-1:0][spk_pkg::WORD_W-1:0] round_keys;
  logic keys_ready;

  // stage s: valid/ready/word at the input of round s; s = ROUNDS is output
  logic          st_valid [ROUNDS+1];
  logic          st_ready [ROUNDS+1];
  spk_pkg::blk_t st_word  [ROUNDS+1];

  assign cfg_ready = 1'b1;

  spk_sched #(.ROUNDS(ROUNDS)) u_sched (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .round_keys (round_keys),
    .keys_ready (keys_ready)
  );

  // hold off inputs while the schedule runs
  assign st_valid[0]   = in_valid && keys_ready;
  assign in_ready      = st_ready[0] && keys_ready;
  assign st_word[0].op = op;
  assign st_word[0].x  = block_high;
  assign st_word[0].y  = block_low;

  // encrypt uses keys in order, decrypt in reverse
  for (genvar s = 0; s < ROUNDS; s++) begin : g_round
    spk_round u_round (
      .clk      (clk),
      .rst      (rst),
      .up_valid (st_valid[s]),
      .up_ready (st_ready[s]),
      .up_word  (st_word[s]),
      .dn_valid (st_valid[s+1]),
      .dn_ready (st_ready[s+1]),
      .dn_word  (st_word[s+1]),
      .rk_enc   (round_keys[s]),
      .rk_dec   (round_keys[ROUNDS-1-s])
    );
  end

  assign out_valid          = st_valid[ROUNDS];
  assign st_ready[ROUNDS]   = out_ready;
  assign out_low            = st_word[ROUNDS].y;
  assign out_high           = st_word[ROUNDS].x;

  // a key write restarts the schedule, so inputs close next cycle
  a_cfg_closes_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && (cfg_index == spk_pkg::REG_KEY_WORD0 ||
                  cfg_index == spk_pkg::REG_KEY_WORD1 ||
                  cfg_index == spk_pkg::REG_KEY_WORD2 ||
                  cfg_index == spk_pkg::REG_KEY_WORD3) |=> !in_ready)
    else $error("input open during key schedule");

  // back pressure at the input only when the output is blocked
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    keys_ready && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // reset starts a fresh schedule
  a_reset_schedules: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input open right after reset");

endmodule
